@@ src/swmr_pkg.sv @@
`default_nettype none

package swmr_pkg;

	localparam int SAMPLE_W       = 32;
	localparam int WIN_REG_W      = 11;
	localparam int WINDOW_MAX_DEF = 1024;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_IDX_WINDOW_SIZE = 1'b0;
	localparam logic [WIN_REG_W-1:0] WIN_RESET = 11'd1;

	// request queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = 1;
	localparam int FIFO_CW    = 2;

	// classified request as it leaves the front
	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                last;
		logic                fresh;
		logic                ge;
	} swmr_item_t;

	// command from the sequencer to both queue units
	typedef struct packed {
		logic                start;
		logic                fresh;
		logic [SAMPLE_W-1:0] value;
	} swmr_cmd_t;

	// status of one queue unit
	typedef struct packed {
		logic                idle;
		logic [SAMPLE_W-1:0] front_val;
	} swmr_qstat_t;

endpackage

`default_nettype wire

@@ src/swmr_ram.sv @@
`default_nettype none

module swmr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] ra_addr,
	output logic      [WIDTH-1:0]         ra_data,
	input  wire logic [$clog2(DEPTH)-1:0] rb_addr,
	output logic      [WIDTH-1:0]         rb_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end

endmodule

`default_nettype wire

@@ src/swmr_front.sv @@
`default_nettype none

module swmr_front import swmr_pkg::*; #(
	parameter int AGW = 11
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic                last_sample,
	input  wire logic [AGW-1:0]      win,
	output logic                     item_valid,
	output swmr_item_t               item,
	output logic      [AGW-1:0]      now_idx,
	input  wire logic                item_pop
);

	swmr_item_t         item_mem [FIFO_DEPTH];
	logic [AGW-1:0]     idx_mem  [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic [31:0]        index_q;
	logic               seq_start_q;
	logic               accept;
	logic               deq;
	swmr_item_t         new_item;

	assign full       = (cnt_q == FIFO_CW'(FIFO_DEPTH));
	assign accept     = push && !full;
	assign item_valid = (cnt_q != '0);
	assign deq        = item_pop && item_valid;
	assign item       = item_mem[rd_ptr_q];
	assign now_idx    = idx_mem[rd_ptr_q];

	// tag each request with its place in the sequence
	always_comb begin
		new_item.value = sample;
		new_item.last  = last_sample;
		new_item.fresh = seq_start_q;
		new_item.ge    = (index_q >= (32'(win) - 32'd1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			cnt_q       <= '0;
			index_q     <= '0;
			seq_start_q <= 1'b1;
		end else begin
			if (accept) begin
				wr_ptr_q    <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
				index_q     <= last_sample ? '0 : index_q + 32'd1;
				seq_start_q <= last_sample;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (accept && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!accept && deq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_mem[wr_ptr_q] <= new_item;
			idx_mem[wr_ptr_q]  <= index_q[AGW-1:0];
		end
	end

endmodule

`default_nettype wire

@@ src/swmr_mono.sv @@
`default_nettype none

module swmr_mono import swmr_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AGW   = 11
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           keep_max,
	input  wire swmr_cmd_t      cmd,
	input  wire logic [AGW-1:0] now_idx,
	input  wire logic [AGW-1:0] win,
	output swmr_qstat_t         stat
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = SAMPLE_W + AGW;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EVICT = 2'd1;
	localparam logic [1:0] ST_POP1  = 2'd2;
	localparam logic [1:0] ST_POPN  = 2'd3;

	logic [1:0]          state_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       tail_q;
	logic [CW-1:0]       cnt_q;
	logic [SAMPLE_W-1:0] front_val_q;
	logic [AGW-1:0]      front_idx_q;
	logic [SAMPLE_W-1:0] back_val_q;
	logic [SAMPLE_W-1:0] val_q;
	logic [AGW-1:0]      now_q;

	logic [EW-1:0]       ra_data;
	logic [EW-1:0]       rb_data;
	logic [AW-1:0]       ra_addr;
	logic [AW-1:0]       rb_addr;
	logic                in_evict;
	logic                in_pop;
	logic [SAMPLE_W-1:0] front_val_c;
	logic [AGW-1:0]      front_idx_c;
	logic [AGW-1:0]      now_c;
	logic [AGW-1:0]      age;
	logic [CW-1:0]       cnt_c;
	logic                evict;
	logic [SAMPLE_W-1:0] back_val_c;
	logic                drop;
	logic                pushing;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
	endfunction

	// next front, and the entry below the current back
	assign ra_addr = ptr_inc(head_q);
	assign rb_addr = ptr_dec(ptr_dec(tail_q));

	assign in_evict = (state_q == ST_IDLE && cmd.start) || (state_q == ST_EVICT);
	assign in_pop   = (state_q == ST_POP1) || (state_q == ST_POPN);

	assign front_val_c = (state_q == ST_EVICT) ? ra_data[EW-1 -: SAMPLE_W] : front_val_q;
	assign front_idx_c = (state_q == ST_EVICT) ? ra_data[AGW-1:0] : front_idx_q;
	assign now_c       = (state_q == ST_IDLE) ? now_idx : now_q;
	assign age         = now_c - front_idx_c;
	assign cnt_c       = (state_q == ST_IDLE && cmd.fresh) ? '0 : cnt_q;
	assign evict       = in_evict && (cnt_c != '0) && (age >= win);

	assign back_val_c = (state_q == ST_POPN) ? rb_data[EW-1 -: SAMPLE_W] : back_val_q;
	assign drop       = (cnt_q != '0) &&
	                    (keep_max ? (back_val_c <= val_q) : (back_val_c >= val_q));
	assign pushing    = in_pop && !drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						if (cmd.fresh) begin
							head_q <= '0;
							tail_q <= '0;
							cnt_q  <= '0;
						end
						if (evict) begin
							head_q  <= ptr_inc(head_q);
							cnt_q   <= cnt_q - 1'b1;
							state_q <= (cnt_q == CW'(1)) ? ST_POP1 : ST_EVICT;
						end else begin
							state_q <= ST_POP1;
						end
					end
				end
				ST_EVICT: begin
					if (evict) begin
						head_q  <= ptr_inc(head_q);
						cnt_q   <= cnt_q - 1'b1;
						state_q <= (cnt_q == CW'(1)) ? ST_POP1 : ST_EVICT;
					end else begin
						state_q <= ST_POP1;
					end
				end
				ST_POP1, ST_POPN: begin
					if (drop) begin
						tail_q  <= ptr_dec(tail_q);
						cnt_q   <= cnt_q - 1'b1;
						state_q <= ST_POPN;
					end else begin
						tail_q  <= ptr_inc(tail_q);
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.start) begin
			val_q <= cmd.value;
			now_q <= now_idx;
		end
		if (state_q == ST_EVICT && !evict) begin
			front_val_q <= front_val_c;
			front_idx_q <= front_idx_c;
		end
		if (pushing) begin
			back_val_q <= val_q;
			if (cnt_q == '0) begin
				front_val_q <= val_q;
				front_idx_q <= now_q;
			end
		end
	end

	swmr_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (pushing),
		.waddr   (tail_q),
		.wdata   ({val_q, now_q}),
		.ra_addr (ra_addr),
		.ra_data (ra_data),
		.rb_addr (rb_addr),
		.rb_data (rb_data)
	);

	assign stat.idle      = (state_q == ST_IDLE);
	assign stat.front_val = front_val_q;

endmodule

`default_nettype wire

@@ src/swmr_engine.sv @@
`default_nettype none

module swmr_engine import swmr_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	input  wire swmr_item_t          item,
	output logic                     item_pop,
	output swmr_cmd_t                cmd,
	input  wire swmr_qstat_t         stat_max,
	input  wire swmr_qstat_t         stat_min,
	output logic                     empty,
	input  wire logic                pop,
	output logic      [SAMPLE_W-1:0] max_spread
);

	logic                busy_q;
	logic                cur_last_q;
	logic                cur_ge_q;
	logic [SAMPLE_W-1:0] best_q;
	logic                full_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_data_q;

	logic                finish;
	logic                start;
	logic [SAMPLE_W-1:0] spread;
	logic                upd;
	logic [SAMPLE_W-1:0] best_new;

	// a last request may only retire when the result register has room
	assign finish = busy_q && stat_max.idle && stat_min.idle &&
	                (!cur_last_q || !out_valid_q || pop);
	assign start  = item_valid && (!busy_q || finish);

	assign item_pop  = start;
	assign cmd.start = start;
	assign cmd.fresh = item.fresh;
	assign cmd.value = item.value;

	assign spread   = stat_max.front_val - stat_min.front_val;
	assign upd      = cur_ge_q || (!full_q && cur_last_q);
	assign best_new = (upd && (spread > best_q)) ? spread : best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			best_q      <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				if (cur_last_q) begin
					best_q <= '0;
					full_q <= 1'b0;
				end else begin
					best_q <= best_new;
					full_q <= full_q || cur_ge_q;
				end
			end
			if (finish && cur_last_q) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_last_q <= item.last;
			cur_ge_q   <= item.ge;
		end
		if (finish && cur_last_q) begin
			out_data_q <= best_new;
		end
	end

	assign empty      = !out_valid_q;
	assign max_spread = out_data_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (stat_max.idle && stat_min.idle))
		else $error("request issued while a queue unit is busy");

	a_spread_order: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> (stat_max.front_val >= stat_min.front_val))
		else $error("window maximum below window minimum");

	a_seq_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && cur_last_q) |=> (best_q == '0 && !full_q && out_valid_q))
		else $error("sequence state not cleared after last request");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop && !finish) |=> (out_valid_q && $stable(out_data_q)))
		else $error("pending result lost or changed");

endmodule

`default_nettype wire

@@ src/sliding_window_max_range_unit.sv @@
// Sliding-window largest spread. Unsigned 32-bit samples are pushed one per request, the
// last of a sequence flagged by last_sample; for every full window of window_size samples
// the unit forms window max minus window min and keeps the largest, and on the last sample
// it queues that value as one result and starts afresh. A sequence shorter than the window
// yields the spread of all its samples. window_size (register 0, byte address 0, reset 1)
// is read as 1 when zero and capped at WINDOW_MAX; write it only while the unit is idle.
// Each sample is handled by both queue units, each ageing entries out at its front and
// dropping dominated entries at its back, and the next sample starts only once both are
// idle; every entry leaves its queue once, so ageing out and dropping amortise to about one
// entry per sample in each queue. Each queue unit walks its circular buffer one entry a
// cycle through the RAM read ports.
// A two-deep request queue sits in front and a one-deep result register behind, so either
// side may stall without holding the other. Queue state is tracked by fill counts, so there
// is no clearing pass after reset.

`default_nettype none

module sliding_window_max_range_unit import swmr_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// request side
	input  wire logic                push,
	output logic                     full,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic                last_sample,
	// result side
	output logic                     empty,
	input  wire logic                pop,
	output logic      [SAMPLE_W-1:0] max_spread,
	// configuration
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [APB_AW-1:0]   paddr,
	input  wire logic [APB_DW-1:0]   pwdata,
	output logic      [APB_DW-1:0]   prdata,
	output logic                     pready
);

	// age arithmetic needs one bit beyond the buffer index so a full-window age is seen
	localparam int AGW = $clog2(WINDOW_MAX) + 1;

	logic [WIN_REG_W-1:0] window_size_q;
	logic                 reg_sel;
	logic [31:0]          ws_ext;
	logic [AGW-1:0]       win;

	logic                 item_valid;
	swmr_item_t           item;
	logic [AGW-1:0]       now_idx;
	logic                 item_pop;
	swmr_cmd_t            cmd;
	swmr_qstat_t          stat_max;
	swmr_qstat_t          stat_min;

	// register decode: one word, anything above it reads as zero and ignores writes
	assign reg_sel = (paddr[APB_AW-1] == REG_IDX_WINDOW_SIZE);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? APB_DW'(window_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WIN_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			window_size_q <= pwdata[WIN_REG_W-1:0];
		end
	end

	// effective window: zero behaves as one, large sizes saturate at the buffer depth
	assign ws_ext = 32'(window_size_q);
	always_comb begin
		if (window_size_q == '0) begin
			win = AGW'(1);
		end else if (ws_ext > 32'(WINDOW_MAX)) begin
			win = AGW'(WINDOW_MAX);
		end else begin
			win = AGW'(window_size_q);
		end
	end

	// front: takes requests, numbers them within the sequence and marks full windows
	swmr_front #(
		.AGW (AGW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.sample      (sample),
		.last_sample (last_sample),
		.win         (win),
		.item_valid  (item_valid),
		.item        (item),
		.now_idx     (now_idx),
		.item_pop    (item_pop)
	);

	// back: sequences one request at a time through both queue units
	swmr_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.cmd        (cmd),
		.stat_max   (stat_max),
		.stat_min   (stat_min),
		.empty      (empty),
		.pop        (pop),
		.max_spread (max_spread)
	);

	// decreasing queue, front holds the window maximum
	swmr_mono #(
		.DEPTH (WINDOW_MAX),
		.AGW   (AGW)
	) u_max_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.keep_max (1'b1),
		.cmd      (cmd),
		.now_idx  (now_idx),
		.win      (win),
		.stat     (stat_max)
	);

	// increasing queue, front holds the window minimum
	swmr_mono #(
		.DEPTH (WINDOW_MAX),
		.AGW   (AGW)
	) u_min_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.keep_max (1'b0),
		.cmd      (cmd),
		.now_idx  (now_idx),
		.win      (win),
		.stat     (stat_min)
	);

endmodule

`default_nettype wire

@@ test/sliding_window_max_range_unit_tb.sv @@
`timescale 1ns / 100ps

module sliding_window_max_range_unit_tb;
	import swmr_pkg::*;

	// three requests in flight, each walking both queues up to their full depth
	localparam int SETTLE_CYCLES  = 6500;
	localparam int WATCHDOG_LIMIT = 20000;  // quiet cycles allowed, well above the settle pause
	localparam int MAX_REPORTS    = 10;
	localparam int PHASES         = 10;
	localparam int MIN_RESULTS    = 48;
	localparam logic [APB_AW-1:0] WINDOW_SIZE_ADDR = APB_AW'({REG_IDX_WINDOW_SIZE, 2'b00});

	// idling modes: none, sender idle, receiver stalling, both
	localparam int unsigned SEND_IDLE[4]  = '{0, 49, 0, 19};
	localparam int unsigned RECV_STALL[4] = '{0, 0, 49, 19};

	// window word, sample budget and longest sequence for each random phase
	localparam logic [31:0] PHASE_WIN[PHASES] = '{3, 1, 0, 16, 1024, 2, 7, 1025, 5, 0};
	localparam int PHASE_BUDGET[PHASES]       = '{50, 50, 40, 60, 60, 50, 50, 30, 50, 60};
	localparam int PHASE_MAX_LEN[PHASES]      = '{12, 6, 6, 40, 30, 8, 20, 20, 14, 48};

	typedef enum int {
		SHAPE_ANY, SHAPE_NEAR, SHAPE_RISE, SHAPE_FALL, SHAPE_FLAT, SHAPE_EDGE
	} value_shape_e;

	typedef struct packed {
		logic [SAMPLE_W-1:0] val;
		logic [31:0]         pos;
	} queue_entry_t;

	// running predictor of the largest window spread, plus the store of spreads still owed
	class spread_board;
		logic [WIN_REG_W-1:0] window_word;
		queue_entry_t         peak_q[$];
		queue_entry_t         floor_q[$];
		logic [31:0]          seq_pos;
		logic [SAMPLE_W-1:0]  best_spread;
		bit                   window_seen;
		logic [SAMPLE_W-1:0]  owed_spreads[$];
		int unsigned          mismatches;
		int unsigned          results_seen;

		function new();
			window_word  = WIN_RESET;
			mismatches   = 0;
			results_seen = 0;
			restart();
		endfunction

		function void restart();
			peak_q.delete();
			floor_q.delete();
			seq_pos     = '0;
			best_spread = '0;
			window_seen = 1'b0;
		endfunction

		function void set_window(logic [WIN_REG_W-1:0] w);
			window_word = w;
		endfunction

		function int unsigned pending();
			return owed_spreads.size();
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] v, logic last);
			logic [31:0]         now;
			logic [SAMPLE_W-1:0] span;
			int unsigned         w;
			queue_entry_t        ent;
			now = seq_pos;
			// zero reads as one, anything above the depth is capped
			w = (window_word == '0) ? 1 :
				(window_word > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : int'(window_word);
			// age out the front of both queues, ages modulo 2^32
			while (peak_q.size() > 0 && (now - peak_q[0].pos) >= w)
				void'(peak_q.pop_front());
			while (floor_q.size() > 0 && (now - floor_q[0].pos) >= w)
				void'(floor_q.pop_front());
			// drop dominated entries from the back, then append
			while (peak_q.size() > 0 && peak_q[$].val <= v)
				void'(peak_q.pop_back());
			while (floor_q.size() > 0 && floor_q[$].val >= v)
				void'(floor_q.pop_back());
			ent.val = v;
			ent.pos = now;
			peak_q  = {peak_q, ent};
			floor_q = {floor_q, ent};
			if (now >= w - 1)
				window_seen = 1'b1;
			span = peak_q[0].val - floor_q[0].val;
			// full windows count; before any is full only the last sample counts (short sequence)
			if ((window_seen || last) && (now >= w - 1 || !window_seen) && span > best_spread)
				best_spread = span;
			seq_pos = now + 1;
			if (last) begin
				owed_spreads = {owed_spreads, best_spread};
				restart();
			end
		endfunction

		function void check_result(logic [SAMPLE_W-1:0] got);
			logic [SAMPLE_W-1:0] want;
			results_seen++;
			if (owed_spreads.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: max_spread %h popped with no request awaiting it", $time, got);
			end else begin
				want = owed_spreads.pop_front();
				if (got !== want)
					flag("max_spread", want, got);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	logic [SAMPLE_W-1:0] sample;
	logic                last_sample;
	logic                empty;
	logic                pop;
	logic [SAMPLE_W-1:0] max_spread;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	spread_board board = new();

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned samples_taken  = 0;
	int unsigned window_writes  = 0;
	int unsigned quiet_cycles   = 0;

	sliding_window_max_range_unit #(
		.WINDOW_MAX(WINDOW_MAX_DEF)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.last_sample(last_sample),
		.empty(empty),
		.pop(pop),
		.max_spread(max_spread),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: decide each cycle whether to take a result
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor: every handshake seen at the rising edge, plus the watchdog on quiet cycles
	always @(posedge clk) begin : monitor
		bit took;
		took = 1'b0;
		if (arst_n) begin
			if (push && !full) begin
				board.note_sample(sample, last_sample);
				samples_taken++;
				took = 1'b1;
			end
			if (pop && !empty) begin
				board.check_result(max_spread);
				took = 1'b1;
			end
			if (psel && penable && pready) begin
				if (pwrite)
					board.set_window(pwdata[WIN_REG_W-1:0]);
				took = 1'b1;
			end
			quiet_cycles = took ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("sliding_window_max_range_unit test failed");
				$finish;
			end
		end
	end

	task automatic set_idling(input int mode);
		send_idle_pct  = SEND_IDLE[mode % 4];
		recv_stall_pct = RECV_STALL[mode % 4];
	endtask

	// one sample request; returns at the edge that accepts it
	task automatic send_sample(input logic [SAMPLE_W-1:0] v, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push        <= 1'b1;
		sample      <= v;
		last_sample <= last;
		do @(posedge clk); while (full);
	endtask

	// hold off the sender until every owed spread has been popped
	task automatic quiesce(input bit settle);
		@(negedge clk);
		push <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		// samples without a result may still be walking the queues
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
			input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// write the window register while idle, then read it back
	task automatic write_window(input logic [APB_DW-1:0] word);
		logic [APB_DW-1:0] rd;
		quiesce(1'b1);
		apb_access(1'b1, WINDOW_SIZE_ADDR, word, rd);
		apb_access(1'b0, WINDOW_SIZE_ADDR, '0, rd);
		if (rd !== APB_DW'(word[WIN_REG_W-1:0]))
			board.flag("window_size readback", APB_DW'(word[WIN_REG_W-1:0]), rd);
		window_writes++;
	endtask

	function automatic logic [SAMPLE_W-1:0] next_value(input value_shape_e shape,
			input logic [SAMPLE_W-1:0] prev, input logic [SAMPLE_W-1:0] base);
		case (shape)
			SHAPE_NEAR: return base + $urandom_range(255);
			SHAPE_RISE: return prev + $urandom_range(1000);
			SHAPE_FALL: return prev - $urandom_range(1000);
			SHAPE_FLAT: return prev;
			SHAPE_EDGE: return $urandom_range(1) ? '1 : '0;
			default:    return $urandom();
		endcase
	endfunction

	// one whole sequence, last_sample on its final request
	task automatic run_sequence(input int len, input value_shape_e shape,
			input logic [SAMPLE_W-1:0] start);
		logic [SAMPLE_W-1:0] base;
		logic [SAMPLE_W-1:0] v;
		base = $urandom();
		v    = start;
		for (int i = 0; i < len; i++) begin
			if (i > 0 || shape != SHAPE_FALL)
				v = next_value(shape, v, base);
			send_sample(v, i == len - 1);
		end
	endtask

	initial begin : stimulus
		int                sent;
		int                len;
		logic [APB_DW-1:0] word;
		arst_n      = 1'b0;
		push        = 1'b0;
		sample      = '0;
		last_sample = 1'b0;
		pop         = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: window of one straight out of reset, every spread is zero
		set_idling(0);
		send_sample(32'd5, 1'b1);
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'd7, 1'b1);
		// window zero reads as one
		write_window(32'd0);
		send_sample(32'd3, 1'b0);
		send_sample(32'd9, 1'b1);
		// full-scale spread across a pair
		write_window(32'd2);
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'd5, 1'b1);
		// short sequence: ends before any window fills
		write_window(32'd4);
		send_sample(32'd10, 1'b0);
		send_sample(32'd2, 1'b0);
		send_sample(32'd7, 1'b1);
		// window shrinks part-way through a sequence
		write_window(32'd3);
		send_sample(32'd1, 1'b0);
		send_sample(32'd100, 1'b0);
		send_sample(32'd50, 1'b0);
		write_window(32'd2);
		send_sample(32'd60, 1'b0);
		send_sample(32'd3, 1'b1);
		// upper write-data bits ignored, and a window above the depth saturates
		write_window(32'hFFFF_F805);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'h0000_0000, 1'b1);
		write_window(32'd2047);
		send_sample(32'h8000_0001, 1'b1);

		// random phases, cycling the idling modes
		for (int p = 0; p < PHASES; p++) begin
			word = (p == PHASES - 1) ? (($urandom() & 32'hFFFF_F800) | $urandom_range(8, 64)) :
				PHASE_WIN[p];
			write_window(word);
			set_idling(p);
			sent = 0;
			while (sent < PHASE_BUDGET[p]) begin
				len = $urandom_range(1, PHASE_MAX_LEN[p]);
				run_sequence(len, value_shape_e'($urandom_range(0, 5)), $urandom());
				sent += len;
				// now and then the sender waits for the result side to drain
				if ($urandom_range(9) == 0)
					quiesce(1'b0);
			end
		end

		// deepest case: a falling run fills the max queue to the saturated window and ages out
		write_window(32'd2047);
		set_idling(3);
		run_sequence(WINDOW_MAX_DEF + 6, SHAPE_FALL, 32'hFFFF_FFFF);

		// top up until enough results have been seen
		set_idling(1);
		while (board.results_seen + board.pending() < MIN_RESULTS)
			run_sequence($urandom_range(1, 12), value_shape_e'($urandom_range(0, 5)), $urandom());

		quiesce(1'b1);
		$display("covered %0d sample requests and %0d results over %0d window settings",
			samples_taken, board.results_seen, window_writes + 1);
		$display("%0d mismatches, %0d results still owed", board.mismatches, board.pending());
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("sliding_window_max_range_unit test passed");
		end else begin
			$display("sliding_window_max_range_unit test failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/swmr_pkg.sv
src/swmr_ram.sv
src/swmr_front.sv
src/swmr_mono.sv
src/swmr_engine.sv
src/sliding_window_max_range_unit.sv
test/sliding_window_max_range_unit_tb.sv
